@@ rtl/svt_pkg.sv @@
// Shared types and codes for the sorted value table.
`default_nettype none
package svt_pkg;

  // Operation codes carried by an input beat; the unused code acts as a search
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_code_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         load;     // capture opcode and value of an accepted beat
    logic         compare;  // register per-cell compare flags
    logic         insert;   // shift cells up and write the value in its slot
    logic         remove;   // shift cells down over the first equal entry
    logic         finish;   // register the result fields
    status_code_t status;   // status code of the result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic found;
    logic full;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/svt_ctrl.sv @@
// Controller state machine for the sorted value table.
`default_nettype none
module svt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  svt_pkg::stat_t stat,
  output svt_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t state;

  // Drive commands from the current state
  always_comb begin
    cmd         = '0;
    cmd.status  = svt_pkg::ST_DONE;
    cmd.load    = start && (state == S_IDLE);
    cmd.compare = (state == S_CMP);
    if (state == S_UPD) begin
      cmd.finish = 1'b1;
      cmd.insert = stat.is_insert && !stat.full;
      cmd.remove = stat.is_remove && stat.found;
      priority if (stat.is_insert && stat.full) begin
        cmd.status = svt_pkg::ST_FULL;
      end else if (stat.is_remove && !stat.found) begin
        cmd.status = svt_pkg::ST_ABSENT;
      end else begin
        cmd.status = svt_pkg::ST_DONE;
      end
    end
  end

  // Hold state, busy and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
            busy  <= 1'b1;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/svt_datapath.sv @@
// Datapath of the sorted value table: a row of compare-and-shift cells.
`default_nettype none
module svt_datapath #(
  parameter int CAPACITY = 16,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  svt_pkg::cmd_t      cmd,
  input  logic        [1:0]  opcode,
  input  logic signed [31:0] value,
  output svt_pkg::stat_t     stat,
  output logic               found,
  output logic        [1:0]  status,
  output logic        [4:0]  entry_count
);

  logic        [1:0]    op_q;
  logic signed [31:0]   value_q;
  logic        [CW-1:0] count;
  logic        [CW-1:0] count_next;
  logic [CAPACITY-1:0]  ge_q;
  logic [CAPACITY-1:0]  eq_q;
  logic signed [31:0]   entries [CAPACITY];

  // Report operation and table state to the controller
  always_comb begin
    stat.is_insert = (op_q == svt_pkg::OP_INSERT);
    stat.is_remove = (op_q == svt_pkg::OP_REMOVE);
    stat.found     = |eq_q;
    stat.full      = (count >= CW'(CAPACITY));
  end

  // Work out the count after this beat
  always_comb begin
    priority if (cmd.insert) begin
      count_next = count + CW'(1);
    end else if (cmd.remove) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  // Capture the beat, hold the count and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    if (cmd.load) begin
      op_q    <= opcode;
      value_q <= value;
    end
    if (cmd.finish) begin
      found       <= stat.found;
      status      <= cmd.status;
      entry_count <= 5'(count_next);
    end
  end

  // One cell per entry: compare locally, then shift or load
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               prev_ge;
    logic signed [31:0] prev_val;
    logic signed [31:0] next_val;
    logic               valid;

    if (g == 0) begin : g_first
      assign prev_ge  = 1'b0;
      assign prev_val = value_q;
    end else begin : g_mid
      assign prev_ge  = ge_q[g-1];
      assign prev_val = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_val = entries[g];
    end else begin : g_upper
      assign next_val = entries[g+1];
    end

    assign valid = (CW'(g) < count);

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        ge_q[g] <= valid && (entries[g] >= value_q);
        eq_q[g] <= valid && (entries[g] == value_q);
      end
      if (cmd.insert) begin
        priority if (prev_ge) begin
          entries[g] <= prev_val;
        end else if (ge_q[g] || (count == CW'(g))) begin
          entries[g] <= value_q;
        end
      end else if (cmd.remove) begin
        if (ge_q[g]) begin
          entries[g] <= next_val;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/sorted_value_table_top.sv @@
// Top level of the sorted value table.
//
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         opcode, value
// result    out        done (one cycle)      found, status, entry_count
//
// Each item runs through accept, per-cell compare, then shift and result
// capture; start is taken again in the cycle that shows done.
// The compare flags of the cell row are registered before the shift, which
// keeps these steps the same regardless of CAPACITY.
// Synchronous active-high reset empties the table; entries need no clearing.
// The receiver cannot stall: done lasts exactly one cycle; its fields hold until the next result.
`default_nettype none
module sorted_value_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  opcode,
  input  logic signed [31:0] value,
  output logic               done,
  output logic               found,
  output logic        [1:0]  status,
  output logic        [4:0]  entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  svt_pkg::cmd_t  cmd;
  svt_pkg::stat_t stat;

  svt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  svt_datapath #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .value       (value),
    .stat        (stat),
    .found       (found),
    .status      (status),
    .entry_count (entry_count)
  );

`ifndef NO_ASSERTIONS
  // An accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // Results are never back to back
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // A failed remove never reports the value as found
  a_absent_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && (status == svt_pkg::ST_ABSENT)) |-> !found)
    else $error("absent remove reported found");

  // A result comes only while the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");
`endif

endmodule
`default_nettype wire
